>>> rtl/core/ssc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants for the segment stabbing counter
// Holds the payload structs of both channels, the command codes, the table
// sizing and the sequencer state type.
// ----------------------------------------------------------------------------
package ssc_pkg;

	localparam int MAX_SEGMENTS = 1024;
	localparam int IDX_W        = $clog2(MAX_SEGMENTS);
	localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
	localparam int COORD_W      = 32;
	localparam int HIT_W        = 11;
	localparam int CMD_W        = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]          cmd;
		logic signed [COORD_W-1:0] seg_start;
		logic signed [COORD_W-1:0] seg_end;
		logic signed [COORD_W-1:0] point_value;
	} seg_in_t;

	typedef struct packed {
		logic [HIT_W-1:0] hit_count;
		logic             status;
	} seg_out_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] seg_start;
		logic signed [COORD_W-1:0] seg_end;
	} seg_pair_t;

	// Control from the sequencer to the match/accumulate unit.
	typedef struct packed {
		logic acc_clear;
		logic sample;
	} scan_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

endpackage
`default_nettype wire

>>> rtl/core/segment_stabbing_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_stabbing_counter: counts stored segments that contain a point
// Keeps a table of up to 1024 closed segments; each transaction clears it,
// appends one segment or asks how many stored segments contain a point.
//
// Request channel: req_valid/req_stall carry one command per transaction.
// The block stalls requests while it works on one; an add to a full table
// is dropped and flagged through status. Response channel: rsp_valid/rsp_stall
// return exactly one result per request, held in an output register.
// Clear, add and unused commands go straight to the result state. Query: the
// table is read one entry per cycle through a single memory read port and
// checked by one pair of comparators, then the drain state and the result
// state follow; a query of an empty table goes straight to the result state.
// The result state loads the result once the output register is free.
// The next request is taken the cycle after the result is loaded, even if
// the receiver still stalls it. While the receiver stalls, a finished result
// waits in the sequencer until the output register is free.
// Reset clears the segment count and the control state; table contents are
// not cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module segment_stabbing_counter (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	output logic              req_stall,
	input  ssc_pkg::seg_in_t  req,
	output logic              rsp_valid,
	input  wire               rsp_stall,
	output ssc_pkg::seg_out_t rsp
);
	import ssc_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]          cnt_q;
	logic [CNT_W-1:0]          idx_q;
	logic                      rd_valid_s1;
	logic                      is_query_q;
	logic                      status_q;
	logic                      rsp_valid_q;
	seg_out_t                  rsp_q;
	logic signed [COORD_W-1:0] point_q;

	logic       accept;
	logic       full;
	logic       last;
	logic       rd_en;
	logic       load_rsp;
	logic       mem_we;
	scan_ctl_t  ctl;
	seg_pair_t  wr_pair;
	seg_pair_t  rd_pair;
	logic [CNT_W-1:0] hits;

	assign accept  = req_valid && !req_stall;
	assign full    = (cnt_q == CNT_W'(MAX_SEGMENTS));
	assign last    = (CNT_W'(idx_q + 1'b1) == cnt_q);
	assign mem_we  = accept && (req.cmd == CMD_ADD) && !full;
	assign wr_pair = '{seg_start: req.seg_start, seg_end: req.seg_end};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((req.cmd == CMD_QUERY) && (cnt_q != '0)) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESULT;
					end
				end
			end
			ST_SCAN: begin
				if (last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (load_rsp) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		req_stall     = 1'b1;
		rd_en         = 1'b0;
		load_rsp      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
			end
			ST_SCAN: begin
				rd_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_RESULT: begin
				load_rsp = !rsp_valid_q || !rsp_stall;
			end
			default: begin
			end
		endcase
	end

	assign ctl.acc_clear = accept;
	assign ctl.sample    = rd_valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			is_query_q  <= 1'b0;
			status_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en;
			if (accept) begin
				idx_q      <= '0;
				is_query_q <= (req.cmd == CMD_QUERY);
				status_q   <= (req.cmd == CMD_ADD) && full;
				if (req.cmd == CMD_CLEAR) begin
					cnt_q <= '0;
				end else if (mem_we) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			point_q <= req.point_value;
		end
		if (load_rsp) begin
			rsp_q.hit_count <= is_query_q ? HIT_W'(hits) : '0;
			rsp_q.status    <= status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	ssc_seg_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data (wr_pair),
		.rd_en   (rd_en),
		.rd_addr (idx_q[IDX_W-1:0]),
		.rd_data (rd_pair)
	);

	ssc_match_acc u_match (
		.clk   (clk),
		.ctl   (ctl),
		.point (point_q),
		.seg   (rd_pair),
		.hits  (hits)
	);

endmodule
`default_nettype wire

>>> rtl/core/ssc_seg_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_seg_mem: segment table storage
// One write port and one read port; each entry holds a start/end pair and
// the read data is registered.
// ----------------------------------------------------------------------------
module ssc_seg_mem (
	input  wire                     clk,
	input  wire                     wr_en,
	input  wire [ssc_pkg::IDX_W-1:0] wr_addr,
	input  ssc_pkg::seg_pair_t      wr_data,
	input  wire                     rd_en,
	input  wire [ssc_pkg::IDX_W-1:0] rd_addr,
	output ssc_pkg::seg_pair_t      rd_data
);
	import ssc_pkg::*;

	seg_pair_t mem [MAX_SEGMENTS];
	seg_pair_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

>>> rtl/core/ssc_match_acc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_match_acc: shared compare and count unit
// Checks one stored segment per cycle against the query point and counts
// the segments that contain it.
// ----------------------------------------------------------------------------
module ssc_match_acc (
	input  wire                               clk,
	input  ssc_pkg::scan_ctl_t                ctl,
	input  wire signed [ssc_pkg::COORD_W-1:0] point,
	input  ssc_pkg::seg_pair_t                seg,
	output logic [ssc_pkg::CNT_W-1:0]         hits
);
	import ssc_pkg::*;

	logic [CNT_W-1:0] acc_q;
	logic             match;

	// A reversed segment fails one of the two compares, so it never matches.
	assign match = (seg.seg_start <= point) && (point <= seg.seg_end);

	always_ff @(posedge clk) begin
		if (ctl.acc_clear) begin
			acc_q <= '0;
		end else if (ctl.sample && match) begin
			acc_q <= acc_q + 1'b1;
		end
	end

	assign hits = acc_q;

endmodule
`default_nettype wire
